// ===== rtl/tgarle_pkg.sv =====
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_BPP    = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // configuration reset values
    localparam logic [2:0]  BPP_RST    = 3'd3;
    localparam logic [15:0] WIDTH_RST  = 16'd640;
    localparam logic [15:0] HEIGHT_RST = 16'd480;

    // packet header fields
    localparam int unsigned HDR_RUN_BIT = 7;
    localparam logic [7:0]  HDR_LEN_MASK = 8'h7F;

    // command queue between front and back
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_AW    = 1;

    // live configuration
    typedef struct packed {
        logic [2:0]  bpp;
        logic [15:0] line_width;
        logic [15:0] image_height;
    } t_cfg;

    // one decoded pixel: first piece and optional second piece of a run
    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  cnt1;
        logic        le1;
        logic        ie1;
        logic        has2;
        logic [7:0]  cnt2;
        logic        le2;
        logic        ie2;
    } t_pix_cmd;

endpackage

`default_nettype wire

// ===== rtl/tgarle_front.sv =====
// ----------------------------------------------------------------------------
// tgarle_front
// Packet parser: takes one byte a beat, tracks headers, assembles pixels,
// keeps the column and row position and emits one command per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [7:0]            i_data,
    input  tgarle_pkg::t_cfg      i_cfg,
    input  wire                   i_full,
    output logic                  o_push,
    output tgarle_pkg::t_pix_cmd  o_cmd
);

    logic        r_expect_hdr, n_expect_hdr;
    logic        r_run, n_run;
    logic [7:0]  r_left, n_left;
    logic [1:0]  r_byte_pos, n_byte_pos;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;

    logic [2:0]  bpp_eff;
    logic        done;
    logic        fire;
    logic [31:0] acc_new;
    logic [16:0] w_eff, h_eff, rem;
    logic [7:0]  cnt, sec_raw, left_dec;
    logic [16:0] row_inc, row_inc2;
    logic        le1, ie1, has2, le2, ie2;
    logic [15:0] col1, row1;

    // effective pixel size and pixel completion
    always_comb begin
        if (i_cfg.bpp == 3'd0) begin
            bpp_eff = 3'd1;
        end else if (i_cfg.bpp > 3'd4) begin
            bpp_eff = 3'd4;
        end else begin
            bpp_eff = i_cfg.bpp;
        end
    end

    assign done    = ({1'b0, r_byte_pos} + 3'd1) >= bpp_eff;
    assign acc_new = r_acc | (32'(i_data) << {r_byte_pos, 3'b000});

    // header and partial bytes never need queue space
    assign o_ready = r_expect_hdr || !done || !i_full;
    assign fire    = i_valid && o_ready;
    assign o_push  = fire && !r_expect_hdr && done;

    // line and image position for this pixel
    always_comb begin
        w_eff    = (i_cfg.line_width == 16'd0) ? 17'h10000 : {1'b0, i_cfg.line_width};
        h_eff    = (i_cfg.image_height == 16'd0) ? 17'h10000 : {1'b0, i_cfg.image_height};
        rem      = ({1'b0, r_col} < w_eff) ? (w_eff - {1'b0, r_col}) : 17'd1;
        cnt      = r_run ? r_left : 8'd1;
        le1      = {9'd0, cnt} >= rem;
        row_inc  = {1'b0, r_row} + 17'd1;
        row_inc2 = {1'b0, r_row} + 17'd2;
        ie1      = le1 && (row_inc >= h_eff);
        col1     = le1 ? 16'd0 : (r_col + {8'd0, cnt});
        row1     = !le1 ? r_row : (ie1 ? 16'd0 : row_inc[15:0]);
        // second piece starts a fresh line, so it may span at most one line
        has2     = r_run && !ie1 && ({9'd0, cnt} > rem);
        sec_raw  = cnt - rem[7:0];
        le2      = {9'd0, sec_raw} >= w_eff;
        ie2      = le2 && (row_inc2 >= h_eff);
        left_dec = (r_left != 8'd0) ? (r_left - 8'd1) : 8'd0;

        o_cmd.value = acc_new;
        o_cmd.cnt1  = le1 ? rem[7:0] : cnt;
        o_cmd.le1   = le1;
        o_cmd.ie1   = ie1;
        o_cmd.has2  = has2;
        o_cmd.cnt2  = le2 ? w_eff[7:0] : sec_raw;
        o_cmd.le2   = le2;
        o_cmd.ie2   = ie2;
    end

    // next state
    always_comb begin
        n_expect_hdr = r_expect_hdr;
        n_run        = r_run;
        n_left       = r_left;
        n_byte_pos   = r_byte_pos;
        n_acc        = r_acc;
        n_col        = r_col;
        n_row        = r_row;
        if (fire) begin
            if (r_expect_hdr) begin
                n_run        = i_data[tgarle_pkg::HDR_RUN_BIT];
                n_left       = (i_data & tgarle_pkg::HDR_LEN_MASK) + 8'd1;
                n_expect_hdr = 1'b0;
                n_byte_pos   = 2'd0;
                n_acc        = 32'd0;
            end else if (!done) begin
                n_byte_pos = r_byte_pos + 2'd1;
                n_acc      = acc_new;
            end else begin
                n_byte_pos = 2'd0;
                n_acc      = 32'd0;
                if (has2) begin
                    n_col = le2 ? 16'd0 : {8'd0, sec_raw};
                    n_row = !le2 ? row_inc[15:0] : (ie2 ? 16'd0 : row_inc2[15:0]);
                end else begin
                    n_col = col1;
                    n_row = row1;
                end
                // packet bookkeeping: runs close after one pixel
                if (r_run || ie1 || left_dec == 8'd0) begin
                    n_expect_hdr = 1'b1;
                    n_run        = 1'b0;
                    n_left       = 8'd0;
                end else begin
                    n_left = left_dec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_hdr <= 1'b1;
            r_run        <= 1'b0;
            r_left       <= 8'd0;
            r_byte_pos   <= 2'd0;
            r_acc        <= 32'd0;
            r_col        <= 16'd0;
            r_row        <= 16'd0;
        end else begin
            r_expect_hdr <= n_expect_hdr;
            r_run        <= n_run;
            r_left       <= n_left;
            r_byte_pos   <= n_byte_pos;
            r_acc        <= n_acc;
            r_col        <= n_col;
            r_row        <= n_row;
        end
    end

    // an emitted pixel covers at least one position
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_cmd.cnt1 != 8'd0) && (!o_cmd.has2 || o_cmd.cnt2 != 8'd0))
        else $error("front: zero repeat count pushed");

    // image end always falls on a line end, and a split only follows a line end
    a_ie_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (!o_cmd.ie1 || o_cmd.le1) && (!o_cmd.has2 || (o_cmd.le1 && !o_cmd.ie1)))
        else $error("front: inconsistent end marks");

endmodule

`default_nettype wire

// ===== rtl/tgarle_fifo.sv =====
// ----------------------------------------------------------------------------
// tgarle_fifo
// Small flop-based command queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_fifo (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  tgarle_pkg::t_pix_cmd  i_cmd,
    output logic                  o_full,
    input  wire                   i_pop,
    output logic                  o_empty,
    output tgarle_pkg::t_pix_cmd  o_head
);

    localparam int unsigned CW = tgarle_pkg::FIFO_AW + 1;

    tgarle_pkg::t_pix_cmd r_mem [tgarle_pkg::FIFO_DEPTH];
    logic [tgarle_pkg::FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [tgarle_pkg::FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]                  r_count, n_count;

    assign o_full  = r_count == CW'(tgarle_pkg::FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // queue never overflows or underflows
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("fifo: push on full or pop on empty");

endmodule

`default_nettype wire

// ===== rtl/tgarle_back.sv =====
// ----------------------------------------------------------------------------
// tgarle_back
// Output stage: turns each queued pixel command into one or two output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_empty,
    input  tgarle_pkg::t_pix_cmd  i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [39:0]           o_data,
    output logic                  o_last,
    output logic                  o_user
);

    logic r_second, n_second;
    logic beat;

    assign o_valid = !i_empty;
    assign beat    = o_valid && i_ready;
    assign o_pop   = beat && (r_second || !i_head.has2);

    // select the piece that goes out now
    always_comb begin
        if (r_second) begin
            o_data = {i_head.cnt2, i_head.value};
            o_last = i_head.le2;
            o_user = i_head.ie2;
        end else begin
            o_data = {i_head.cnt1, i_head.value};
            o_last = i_head.le1;
            o_user = i_head.ie1;
        end
    end

    always_comb begin
        n_second = r_second;
        if (o_pop) begin
            n_second = 1'b0;
        end else if (beat) begin
            n_second = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

    // second piece is only sent for a split run
    a_second_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (!i_empty && i_head.has2))
        else $error("back: second piece without split");

endmodule

`default_nettype wire

// ===== rtl/tga_rle_pixel_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// TGA run-length pixel decoder: packet bytes in, pixels with repeat counts
// and line / image end marks out.
//
// Channel   Dir  Beat contents
// s_*       in   tdata[7:0] data_byte
// m_*       out  tdata[31:0] pixel_value, [39:32] repeat_count;
//                tlast line_end; tuser image_end
// APB       in   reg 0 bytes_per_pixel, 1 line_width, 2 image_height
//
// One byte is taken every cycle unless a finished pixel finds the queue full.
// Each pixel goes out as one beat; a run that crosses a line end goes out as
// two beats from the output stage. A two-entry command queue lets input and output
// stall on their own. Reset is synchronous, active low, needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // byte stream in
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,     // [7:0] data_byte
    // pixel stream out
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata,     // [31:0] pixel_value, [39:32] repeat_count
    output logic        o_m_tlast,
    output logic        o_m_tuser,     // [0] image_end
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tgarle_pkg::t_cfg     r_cfg;
    tgarle_pkg::t_pix_cmd push_cmd, head_cmd;
    logic                 push, pop, full, empty;
    logic                 cfg_wr;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bpp          <= tgarle_pkg::BPP_RST;
            r_cfg.line_width   <= tgarle_pkg::WIDTH_RST;
            r_cfg.image_height <= tgarle_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                tgarle_pkg::REG_BPP:    r_cfg.bpp          <= pwdata[2:0];
                tgarle_pkg::REG_WIDTH:  r_cfg.line_width   <= pwdata[15:0];
                tgarle_pkg::REG_HEIGHT: r_cfg.image_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            tgarle_pkg::REG_BPP:    prdata = {29'd0, r_cfg.bpp};
            tgarle_pkg::REG_WIDTH:  prdata = {16'd0, r_cfg.line_width};
            tgarle_pkg::REG_HEIGHT: prdata = {16'd0, r_cfg.image_height};
            default:                prdata = 32'd0;
        endcase
    end

    tgarle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    tgarle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_cmd)
    );

    tgarle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_user  (o_m_tuser)
    );

endmodule

`default_nettype wire
